// ----- rtl/positional_ordered_list_top_defines.svh -----
// Assertion macros shared by the checker file of this block.
// Each macro is clocked on clk_i and is quiet while rst_ni is low.
`ifndef POSITIONAL_ORDERED_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_TOP_DEFINES_SVH

// Same-cycle implication.
`define POL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define POL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pol_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

  // Number of cells in the list.
  localparam int CAPACITY = 16;

  // Field widths.
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 2;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  // Fill count holds 0 to CAPACITY; compares run at the wider of count and position.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // One stored pair.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] weight;
  } entry_t;

  // Per-cell controls from the list controller.
  typedef struct packed {
    logic load;
    logic shift;
    logic hit;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/pol_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pol_cell (
  input  logic                clk_i,
  input  pol_pkg::cell_ctrl_t ctrl_i,
  input  pol_pkg::entry_t     wr_entry_i,
  input  pol_pkg::entry_t     nbr_entry_i,
  input  pol_pkg::entry_t     rd_chain_i,
  output pol_pkg::entry_t     rd_chain_o,
  output pol_pkg::entry_t     entry_o
);
  import pol_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // A cell takes the appended pair, or the pair of its tail-side neighbor
  // when a removal closes the gap, and otherwise holds.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = wr_entry_i;
    end else if (ctrl_i.shift) begin
      entry_d = nbr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // The addressed cell puts its pair on the read chain toward the head.
  assign rd_chain_o = ctrl_i.hit ? entry_q : rd_chain_i;
  assign entry_o    = entry_q;

endmodule

`default_nettype wire

// ----- rtl/positional_ordered_list_top.sv -----
// Bounded ordered list of (value, weight) pairs held in a row of CAPACITY
// cells: append at the tail, read at a position, or remove at a position with
// later entries moving up one cell. Every request gives one result with the
// pair, a status and the new length; a bad position, an empty list or an
// unused operation code gives -1 values and a bad-position status, and an
// append to a full list gives -1 values and a full status. A new request is
// accepted every cycle while the result register is empty or being taken,
// and the result is registered and appears in the cycle after its request.
// The read path runs through a mux in every cell from the tail to the head,
// so its depth grows with CAPACITY and sets the clock limit.
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pol_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [pol_pkg::VAL_W-1:0]   in_value_i,
  input  logic signed [pol_pkg::VAL_W-1:0]   in_weight_i,
  input  logic [pol_pkg::POS_W-1:0]          position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pol_pkg::VAL_W-1:0]   out_value_o,
  output logic signed [pol_pkg::VAL_W-1:0]   out_weight_o,
  output logic [pol_pkg::STAT_W-1:0]         status_o,
  output logic [pol_pkg::LEN_W-1:0]          length_o
);
  import pol_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic              in_acc;
  logic              is_app;
  logic              is_rd;
  logic              is_rm;
  logic              full;
  logic              pos_ok;
  logic              app_ok;
  logic              rm_ok;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  entry_t            wr_entry;
  entry_t            res_entry;
  status_e           res_status;
  entry_t            cell_entry [CAPACITY];
  entry_t            rd_chain   [CAPACITY+1];
  cell_ctrl_t        cell_ctrl  [CAPACITY];

  logic              out_valid_q;
  entry_t            out_entry_q;
  status_e           out_status_q;
  logic [LEN_W-1:0]  out_len_q;

  // Handshake: a new request enters while the result register is free or draining.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode the request against the current fill count.
  assign is_app  = (func_i == OP_APPEND);
  assign is_rd   = (func_i == OP_READ);
  assign is_rm   = (func_i == OP_REMOVE);
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign pos_ok  = (is_rd || is_rm) && (pos_ext < cnt_ext);
  assign app_ok  = in_acc && is_app && !full;
  assign rm_ok   = in_acc && is_rm && pos_ok;

  assign wr_entry.value  = in_value_i;
  assign wr_entry.weight = in_weight_i;

  // Nothing is addressed past the tail; the chain starts as all ones.
  assign rd_chain[CAPACITY] = '1;

  // The row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctrl[i].hit   = (pos_ext == CMP_W'(i));
    assign cell_ctrl[i].load  = app_ok && (count_q == CNT_W'(i));
    assign cell_ctrl[i].shift = rm_ok && (CMP_W'(i) >= pos_ext);

    if (i == CAPACITY - 1) begin : g_last
      pol_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .wr_entry_i  (wr_entry),
        .nbr_entry_i (wr_entry),
        .rd_chain_i  (rd_chain[i+1]),
        .rd_chain_o  (rd_chain[i]),
        .entry_o     (cell_entry[i])
      );
    end else begin : g_mid
      pol_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .wr_entry_i  (wr_entry),
        .nbr_entry_i (cell_entry[i+1]),
        .rd_chain_i  (rd_chain[i+1]),
        .rd_chain_o  (rd_chain[i]),
        .entry_o     (cell_entry[i])
      );
    end
  end

  // Fill count after this request.
  always_comb begin
    count_d = count_q;
    if (app_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (rm_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Result of this request.
  always_comb begin
    res_entry  = '1;
    res_status = ST_BADPOS;
    if (is_app) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        res_entry  = wr_entry;
        res_status = ST_OK;
      end
    end else if (pos_ok) begin
      res_entry  = rd_chain[0];
      res_status = ST_OK;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_entry_q  <= res_entry;
      out_status_q <= res_status;
      out_len_q    <= LEN_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_entry_q.value;
  assign out_weight_o = out_entry_q.weight;
  assign status_o     = out_status_q;
  assign length_o     = out_len_q;

endmodule

`default_nettype wire

// ----- rtl/pol_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "positional_ordered_list_top_defines.svh"

module pol_chk (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_o,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic signed [pol_pkg::VAL_W-1:0]   out_value_o,
  input  logic signed [pol_pkg::VAL_W-1:0]   out_weight_o,
  input  logic [pol_pkg::STAT_W-1:0]         status_o,
  input  logic [pol_pkg::LEN_W-1:0]          length_o
);
  import pol_pkg::*;

  // A stalled result stays offered.
  `POL_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // Every error result carries all-ones value and weight.
  `POL_ASSERT_IMP(a_err_ones, out_valid_o && (status_o != ST_OK), (out_value_o == '1) && (out_weight_o == '1), "error result not all ones")

  // A full status reports a list at capacity.
  `POL_ASSERT_IMP(a_full_len, out_valid_o && (status_o == ST_FULL), length_o == LEN_W'(CAPACITY), "full status with short list")

  // An accepted request always produces a result in the next cycle.
  `POL_ASSERT_NXT(a_req_res, in_valid_i && !in_stall_o, out_valid_o, "request without result")

endmodule

bind positional_ordered_list_top pol_chk u_pol_chk (.*);

`default_nettype wire
